### rtl/rmh_pkg.sv
`default_nettype none
package rmh_pkg;

  localparam int SampleW     = 32;
  localparam int MaxSamplesD = 1024;

  typedef enum logic {
    HOP_INSERT = 1'b0,
    HOP_REMOVE = 1'b1
  } heap_op_t;

  // command from the sequencer to one heap
  typedef struct packed {
    logic                      go;
    logic                      clear;
    heap_op_t                  op;
    logic signed [SampleW-1:0] value;
  } heap_cmd_t;

  // status from one heap back to the sequencer
  typedef struct packed {
    logic                      done;
    logic signed [SampleW-1:0] top;
  } heap_stat_t;

endpackage
`default_nettype wire

### rtl/running_median_two_heaps.sv
// A dropped sample (store full) goes from the check straight to the result, skipping
//   the heaps; other samples are inserted, sifted and rebalanced first.
// Flow: one item at a time; a new item is taken while the last result waits.
// Reset (rst, synchronous): both heaps empty, no result pending; heap memory
//   contents are not cleared.
`default_nettype none
module running_median_two_heaps import rmh_pkg::*; #(
  parameter int  MAX_SAMPLES = MaxSamplesD,
  localparam int DEPTH = MAX_SAMPLES / 2 + 1,
  localparam int HCW   = $clog2(DEPTH + 1),
  localparam int CNTW  = $clog2(MAX_SAMPLES + 1),
  localparam int OUTB  = SampleW + 1 + CNTW + 1,
  localparam int OUTW  = ((OUTB + 7) / 8) * 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [31:0]     s_tdata,  // sample
  input  wire logic            s_tuser,  // restart
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [OUTW-1:0]      m_tdata   // median_doubled, sample_count, store_full
);

  typedef enum logic [6:0] {
    C_IDLE  = 7'b0000001,
    C_CHK   = 7'b0000010,
    C_INS_W = 7'b0000100,
    C_BAL   = 7'b0001000,
    C_REM_W = 7'b0010000,
    C_MOV_W = 7'b0100000,
    C_OUT   = 7'b1000000
  } cstate_t;

  cstate_t state;
  logic signed [SampleW-1:0] smp, mv;
  logic full, up_src;
  heap_cmd_t ucmd, lcmd;
  heap_stat_t ustat, lstat;
  logic [HCW-1:0] ucnt, lcnt;
  logic [CNTW-1:0] total;
  logic signed [SampleW:0] med;
  logic any_done;

  rmh_heap #(.DEPTH(DEPTH), .IS_MIN(1'b1)) u_upper (
    .clk(clk), .rst(rst), .cmd(ucmd), .stat(ustat), .count(ucnt));
  rmh_heap #(.DEPTH(DEPTH), .IS_MIN(1'b0)) u_lower (
    .clk(clk), .rst(rst), .cmd(lcmd), .stat(lstat), .count(lcnt));

  assign total    = CNTW'(ucnt) + CNTW'(lcnt);
  assign any_done = ustat.done | lstat.done;
  assign s_tready = (state == C_IDLE);

  // median of held samples, doubled
  always_comb begin
    if (total == '0) med = '0;
    else if (total[0]) med = (ucnt > lcnt) ? {ustat.top, 1'b0} : {lstat.top, 1'b0};
    else med = (SampleW+1)'(ustat.top) + (SampleW+1)'(lstat.top);
  end

  // heap commands
  always_comb begin
    ucmd       = '0;
    lcmd       = '0;
    ucmd.op    = HOP_INSERT;
    lcmd.op    = HOP_INSERT;
    ucmd.value = smp;
    lcmd.value = smp;
    case (state)
      C_IDLE: begin
        ucmd.clear = s_tvalid & s_tuser;
        lcmd.clear = s_tvalid & s_tuser;
      end
      C_CHK: begin
        if (total < CNTW'(MAX_SAMPLES)) begin
          if (ucnt == '0 || smp >= ustat.top) ucmd.go = 1'b1;
          else lcmd.go = 1'b1;
        end
      end
      C_BAL: begin
        if (ucnt > lcnt + HCW'(1)) begin
          ucmd.go = 1'b1;
          ucmd.op = HOP_REMOVE;
        end else if (lcnt > ucnt + HCW'(1)) begin
          lcmd.go = 1'b1;
          lcmd.op = HOP_REMOVE;
        end
      end
      C_REM_W: begin
        if (any_done) begin
          lcmd.go    = up_src;
          ucmd.go    = !up_src;
          lcmd.value = mv;
          ucmd.value = mv;
        end
      end
      default: ;
    endcase
  end

  // item sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= C_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == C_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        C_IDLE: if (s_tvalid) state <= C_CHK;
        C_CHK: state <= (total < CNTW'(MAX_SAMPLES)) ? C_INS_W : C_OUT;
        C_INS_W: if (any_done) state <= C_BAL;
        C_BAL: begin
          if (ucnt > lcnt + HCW'(1) || lcnt > ucnt + HCW'(1)) state <= C_REM_W;
          else state <= C_OUT;
        end
        C_REM_W: if (any_done) state <= C_MOV_W;
        C_MOV_W: if (any_done) state <= C_OUT;
        C_OUT: begin
          if (!m_tvalid || m_tready) state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  // item payload and result register
  always_ff @(posedge clk) begin
    if (state == C_IDLE && s_tvalid) smp <= s_tdata;
    if (state == C_CHK) full <= (total >= CNTW'(MAX_SAMPLES));
    if (state == C_BAL) begin
      up_src <= (ucnt > lcnt + HCW'(1));
      mv     <= (ucnt > lcnt + HCW'(1)) ? ustat.top : lstat.top;
    end
    if (state == C_OUT && (!m_tvalid || m_tready))
      m_tdata <= OUTW'({full, total, med});
  end

endmodule
`default_nettype wire

### rtl/rmh_heap.sv
`default_nettype none
module rmh_heap import rmh_pkg::*; #(
  parameter int  DEPTH  = MaxSamplesD / 2 + 1,
  parameter bit  IS_MIN = 1'b1,
  localparam int AW     = $clog2(DEPTH),
  localparam int CW     = $clog2(DEPTH + 1)
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire heap_cmd_t cmd,
  output heap_stat_t     stat,
  output logic [CW-1:0]  count
);

  typedef enum logic [6:0] {
    H_IDLE    = 7'b0000001,
    H_UP_RD   = 7'b0000010,
    H_UP_CMP  = 7'b0000100,
    H_UP_FIN  = 7'b0001000,
    H_DN_LAST = 7'b0010000,
    H_DN_RDL  = 7'b0100000,
    H_DN_RDR  = 7'b1000000
  } hstate_t;

  hstate_t state, state_next;
  logic dn_cmp, dn_cmp_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [AW-1:0] idx, idx_next;
  logic signed [SampleW-1:0] val, val_next, lval, lval_next, top, rdata;
  logic done, done_next;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic signed [SampleW-1:0] wdata;
  logic signed [SampleW-1:0] mem [DEPTH];

  logic [AW-1:0] par;
  logic [AW:0] lch, rch;
  logic signed [SampleW-1:0] bv;
  logic sel_l, sel_r;

  function automatic logic ranks(input logic signed [SampleW-1:0] a,
                                 input logic signed [SampleW-1:0] b);
    ranks = IS_MIN ? (a < b) : (a > b);
  endfunction

  assign par = (idx - AW'(1)) >> 1;
  assign lch = {idx, 1'b1};
  assign rch = lch + (AW+1)'(1);

  // best of hole value, left and right child; ties keep the earlier one
  always_comb begin
    bv    = val;
    sel_l = 1'b0;
    sel_r = 1'b0;
    if (ranks(lval, val)) begin
      bv    = lval;
      sel_l = 1'b1;
    end
    if ((rch < (AW+1)'(cnt)) && ranks(rdata, bv)) begin
      bv    = rdata;
      sel_l = 1'b0;
      sel_r = 1'b1;
    end
  end

  // sift sequencer
  always_comb begin
    state_next  = state;
    dn_cmp_next = 1'b0;
    cnt_next    = cnt;
    idx_next    = idx;
    val_next    = val;
    lval_next   = lval;
    done_next   = 1'b0;
    we          = 1'b0;
    waddr       = idx;
    wdata       = val;
    raddr       = par;
    case (state)
      H_IDLE: begin
        if (cmd.clear) cnt_next = '0;
        if (cmd.go) begin
          if (cmd.op == HOP_INSERT) begin
            val_next = cmd.value;
            idx_next = cnt[AW-1:0];
            cnt_next = cnt + CW'(1);
            if (cnt == '0) begin
              we        = 1'b1;
              waddr     = '0;
              wdata     = cmd.value;
              done_next = 1'b1;
            end else begin
              state_next = H_UP_RD;
            end
          end else begin
            cnt_next = cnt - CW'(1);
            idx_next = '0;
            raddr    = AW'(cnt - CW'(1));
            if (cnt == CW'(1)) done_next = 1'b1;
            else state_next = H_DN_LAST;
          end
        end
      end
      H_UP_RD: begin
        raddr      = par;
        state_next = H_UP_CMP;
      end
      H_UP_CMP: begin
        we = 1'b1;
        if (ranks(val, rdata)) begin
          wdata      = rdata;
          idx_next   = par;
          state_next = (par == '0) ? H_UP_FIN : H_UP_RD;
        end else begin
          done_next  = 1'b1;
          state_next = H_IDLE;
        end
      end
      H_UP_FIN: begin
        we         = 1'b1;
        done_next  = 1'b1;
        state_next = H_IDLE;
      end
      H_DN_LAST: begin
        val_next   = rdata;
        state_next = H_DN_RDL;
      end
      H_DN_RDL: begin
        if (dn_cmp) begin
          // right child data in rdata, left child in lval
          if (!sel_l && !sel_r) begin
            we         = 1'b1;
            done_next  = 1'b1;
            state_next = H_IDLE;
          end else begin
            we          = 1'b1;
            wdata       = bv;
            idx_next    = sel_l ? lch[AW-1:0] : rch[AW-1:0];
            state_next  = H_DN_RDL;
          end
        end else if (lch >= (AW+1)'(cnt)) begin
          we         = 1'b1;
          done_next  = 1'b1;
          state_next = H_IDLE;
        end else begin
          raddr      = lch[AW-1:0];
          state_next = H_DN_RDR;
        end
      end
      H_DN_RDR: begin
        lval_next   = rdata;
        raddr       = rch[AW-1:0];
        dn_cmp_next = 1'b1;
        state_next  = H_DN_RDL;
      end
      default: state_next = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= H_IDLE;
      dn_cmp <= 1'b0;
      cnt    <= '0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      dn_cmp <= dn_cmp_next;
      cnt    <= cnt_next;
      done   <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    val  <= val_next;
    lval <= lval_next;
    if (we && waddr == '0) top <= wdata;
  end

  // heap storage, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  assign stat.done = done;
  assign stat.top  = top;
  assign count     = cnt;

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH)) else $error("heap count above depth");
  a_go_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.go |-> state == H_IDLE) else $error("heap command while busy");
  a_top_mirror: assert property (@(posedge clk) disable iff (rst)
    (we && waddr == '0) |=> top == $past(wdata)) else $error("top register stale");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == H_IDLE) else $error("done while busy");

endmodule
`default_nettype wire
